### rtl/lirs_pkg.sv
// Shared constants, codes and control types for the linear-interpolation resampler.
`timescale 1ns / 1ps
package lirs_pkg;

	// fixed output rate and clip limit
	localparam int unsigned OUTPUT_RATE = 48000;
	localparam int unsigned MAX_SECONDS = 600;

	// field and state widths
	localparam int SAMPLE_W = 16;
	localparam int RATE_W   = 18;
	localparam int PHASE_W  = 16;
	localparam int SUM_W    = 18;
	localparam int FA_W     = 8;
	localparam int COUNT_W  = 25;
	localparam int SLACK_W  = 19;
	localparam int PROD_W   = 4;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;

	// input rate saturation bounds
	localparam logic [RATE_W-1:0] RATE_MIN = RATE_W'(8000);
	localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(192000);

	// most samples one clip may produce
	localparam logic [COUNT_W-1:0] MAX_OUT = COUNT_W'(OUTPUT_RATE * MAX_SECONDS);

	// results per item beyond this are dropped
	localparam logic [PROD_W-1:0] RESULT_CAP = PROD_W'(12);

	// divide by 48000 = (x >> 7) / 375, via reciprocal floor(2^32 / 375)
	localparam int PRE_SH = 7;
	localparam int RECIP_W = 24;
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(11453246);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO     = 1'd1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_SAMPLE   = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic in_ready;
		logic held_step;
		logic start;
		logic fa_dec;
		logic resolve;
		logic last_step;
		logic last_done;
		logic flush;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic in_valid;
		logic in_last;
		logic have_prev;
		logic last_q;
		logic fa_zero;
		logic last_cond;
		logic res_valid;
		logic put_ok;
	} stat_t;

endpackage

### rtl/lirs_if.sv
// Valid/ready channel interfaces for input frames and output results.
`timescale 1ns / 1ps
interface lirs_in_if
	import lirs_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                       last_frame;

	modport source (output valid, left_sample, right_sample, last_frame, input ready);
	modport sink   (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

interface lirs_out_if
	import lirs_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_sample;
	logic [STATUS_W-1:0]        status;
	logic                       last_out;

	modport source (output valid, out_sample, status, last_out, input ready);
	modport sink   (input valid, out_sample, status, last_out, output ready);
endinterface

### rtl/lirs_interp.sv
// Four-stage interpolation unit: (a*(R-f) + b*f) / R truncated toward zero.
`timescale 1ns / 1ps
module lirs_interp
	import lirs_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       clear,
	input  logic signed [SAMPLE_W-1:0] a,
	input  logic signed [SAMPLE_W-1:0] b,
	input  logic [PHASE_W-1:0]         f,
	output logic                       res_valid,
	output logic signed [SAMPLE_W-1:0] res_val
);
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PR_W   = DIFF_W + PHASE_W + 1;
	localparam int ABS_W  = 31;
	localparam int MP_W   = 2 * RECIP_W;
	localparam int Q_W    = SAMPLE_W;
	localparam int QM_W   = 32;
	localparam logic signed [PR_W-1:0] RATE_S = PR_W'(OUTPUT_RATE);

	logic                     v_s1, v_s2, v_s3;
	logic signed [PR_W-1:0]   prod_s1;
	logic signed [SAMPLE_W-1:0] a_s1;
	logic [ABS_W-1:0]         abs_s2, abs_s3;
	logic                     neg_s2, neg_s3;
	logic [Q_W-1:0]           qe_s3;
	logic                     res_valid_q;
	logic signed [SAMPLE_W-1:0] res_q;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PR_W-1:0]   prod;
	logic signed [PR_W-1:0]   vsum;
	logic [PR_W-1:0]          vabs;
	logic [MP_W-1:0]          mp;
	logic [QM_W-1:0]          qm;
	logic [QM_W-1:0]          rem;
	logic [Q_W:0]             q;
	logic [Q_W:0]             qs;

	// stage 1: slope times fraction
	assign diff = DIFF_W'(b) - DIFF_W'(a);
	assign prod = PR_W'(diff) * $signed(PR_W'({1'b0, f}));

	// stage 2: add a*R, split sign and magnitude
	assign vsum = PR_W'(a_s1) * RATE_S + prod_s1;
	assign vabs = vsum[PR_W-1] ? PR_W'(-vsum) : PR_W'(vsum);

	// stage 3: quotient estimate, low by at most one
	assign mp = MP_W'(abs_s2[ABS_W-1:PRE_SH]) * MP_W'(RECIP_M);

	// stage 4: correct estimate, restore sign
	assign qm  = QM_W'(qe_s3) * QM_W'(OUTPUT_RATE);
	assign rem = QM_W'(abs_s3) - qm;
	assign q   = (Q_W + 1)'(qe_s3) + (Q_W + 1)'(rem >= QM_W'(OUTPUT_RATE));
	assign qs  = neg_s3 ? (Q_W + 1)'(-q) : q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				res_valid_q <= 1'b1;
			end else if (clear) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= prod;
			a_s1    <= a;
		end
		if (v_s1) begin
			abs_s2 <= vabs[ABS_W-1:0];
			neg_s2 <= vsum[PR_W-1];
		end
		if (v_s2) begin
			qe_s3  <= mp[MP_W-1 -: Q_W];
			abs_s3 <= abs_s2;
			neg_s3 <= neg_s2;
		end
		if (v_s3) begin
			res_q <= qs[Q_W-1:0];
		end
	end

	assign res_valid = res_valid_q;
	assign res_val   = res_q;

endmodule

### rtl/lirs_dp.sv
// Datapath: config, clip state, phase accumulator, held output and result registers.
`timescale 1ns / 1ps
module lirs_dp
	import lirs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [RATE_W-1:0]     cfg_data,
	lirs_in_if.sink               in_ch,
	lirs_out_if.source            out_ch,
	input  cmd_t                  cmd,
	output stat_t                 st
);
	localparam logic [SUM_W-1:0] R1 = SUM_W'(OUTPUT_RATE);
	localparam logic [SUM_W-1:0] R2 = SUM_W'(2 * OUTPUT_RATE);
	localparam logic [SUM_W-1:0] R3 = SUM_W'(3 * OUTPUT_RATE);
	localparam logic [SUM_W-1:0] R4 = SUM_W'(4 * OUTPUT_RATE);
	localparam int K_W = 3;

	// configuration
	logic [RATE_W-1:0]          rate_cfg_q;
	logic                       stereo_q;

	// current item
	logic signed [SAMPLE_W-1:0] b_q;
	logic                       last_q;
	logic [RATE_W-1:0]          rate_q;
	logic [PROD_W-1:0]          produced_q;

	// clip state
	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       have_prev_q;
	logic [PHASE_W-1:0]         phase_q;
	logic [FA_W-1:0]            fa_q;
	logic [COUNT_W-1:0]         count_q;
	logic                       err_q;
	logic signed [SAMPLE_W-1:0] held_val_q;
	logic                       held_valid_q;
	logic signed [SLACK_W-1:0]  slack_q;

	// pending result and output register
	logic                       pend_valid_q;
	logic signed [SAMPLE_W-1:0] pend_sample_q;
	status_t                    pend_status_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	status_t                    out_status_q;
	logic                       out_last_q;

	logic                       accept;
	logic signed [SAMPLE_W:0]   lr_sum;
	logic signed [SAMPLE_W:0]   lr_adj;
	logic signed [SAMPLE_W-1:0] b_in;
	logic [RATE_W-1:0]          rate_cl;
	logic [SUM_W-1:0]           s;
	logic [K_W-1:0]             adv_k;
	logic [SUM_W-1:0]           adv_phase;
	logic signed [SLACK_W-1:0]  slack_dec;
	logic signed [SLACK_W-1:0]  slack_new;
	logic                       slack_le;
	logic                       fits;
	logic                       res_valid;
	logic signed [SAMPLE_W-1:0] res_val;
	logic                       emit_req;
	logic signed [SAMPLE_W-1:0] emit_val;
	logic                       too_long;
	logic                       put_req;
	logic                       put_go;
	logic signed [SAMPLE_W-1:0] put_sample;
	status_t                    put_status;
	logic                       out_free;
	logic                       push_pend;

	assign accept = in_ch.valid && cmd.in_ready;

	// downmix (L+R)/2 truncated toward zero
	assign lr_sum = (SAMPLE_W + 1)'(in_ch.left_sample) + (SAMPLE_W + 1)'(in_ch.right_sample);
	assign lr_adj = lr_sum + (SAMPLE_W + 1)'({1'b0, lr_sum[SAMPLE_W]});
	assign b_in   = stereo_q ? lr_adj[SAMPLE_W:1] : in_ch.left_sample;

	// rate saturation
	always_comb begin
		if (rate_cfg_q < RATE_MIN) begin
			rate_cl = RATE_MIN;
		end else if (rate_cfg_q > RATE_MAX) begin
			rate_cl = RATE_MAX;
		end else begin
			rate_cl = rate_cfg_q;
		end
	end

	// phase advance: whole frames and remaining fraction
	assign s = SUM_W'(phase_q) + SUM_W'(rate_q);
	always_comb begin
		if (s >= R4) begin
			adv_k = K_W'(4);
			adv_phase = s - R4;
		end else if (s >= R3) begin
			adv_k = K_W'(3);
			adv_phase = s - R3;
		end else if (s >= R2) begin
			adv_k = K_W'(2);
			adv_phase = s - R2;
		end else if (s >= R1) begin
			adv_k = K_W'(1);
			adv_phase = s - R1;
		end else begin
			adv_k = '0;
			adv_phase = s;
		end
	end

	// held output bookkeeping
	assign slack_dec = slack_q - SLACK_W'(OUTPUT_RATE);
	assign slack_le  = slack_dec[SLACK_W-1] || (slack_dec == '0);
	assign slack_new = SLACK_W'(s) - SLACK_W'(R2);
	assign fits      = (s <= R2);

	lirs_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start),
		.clear     (cmd.resolve),
		.a         (prev_q),
		.b         (b_q),
		.f         (phase_q),
		.res_valid (res_valid),
		.res_val   (res_val)
	);

	// sample emission request
	always_comb begin
		emit_req = 1'b0;
		emit_val = '0;
		if (cmd.held_step) begin
			emit_req = held_valid_q && slack_le;
			emit_val = held_val_q;
		end else if (cmd.resolve) begin
			emit_req = fits;
			emit_val = res_val;
		end else if (cmd.last_step) begin
			emit_req = 1'b1;
			emit_val = b_q;
		end
	end

	// result formation, length check and cap
	assign too_long = (count_q >= MAX_OUT);
	always_comb begin
		put_req    = 1'b0;
		put_sample = '0;
		put_status = ST_SAMPLE;
		if (cmd.last_done) begin
			put_req    = (count_q == '0) && !err_q;
			put_status = ST_EMPTY;
		end else if (emit_req && !err_q) begin
			put_req = 1'b1;
			if (too_long) begin
				put_status = ST_TOO_LONG;
			end else begin
				put_sample = emit_val;
			end
		end
	end
	assign put_go    = put_req && (produced_q < RESULT_CAP);
	assign out_free  = !out_valid_q || out_ch.ready;
	assign push_pend = pend_valid_q && (put_go || cmd.flush);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_cfg_q <= RATE_W'(48000);
			stereo_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INPUT_RATE: rate_cfg_q <= cfg_data;
				REG_STEREO:     stereo_q   <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// item and clip state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q          <= '0;
			last_q       <= 1'b0;
			rate_q       <= '0;
			produced_q   <= '0;
			prev_q       <= '0;
			have_prev_q  <= 1'b0;
			phase_q      <= '0;
			fa_q         <= '0;
			count_q      <= '0;
			err_q        <= 1'b0;
			held_val_q   <= '0;
			held_valid_q <= 1'b0;
			slack_q      <= '0;
		end else begin
			if (accept) begin
				b_q        <= b_in;
				last_q     <= in_ch.last_frame;
				rate_q     <= rate_cl;
				produced_q <= '0;
				if (!have_prev_q) begin
					prev_q      <= b_in;
					have_prev_q <= 1'b1;
				end
			end
			if (cmd.held_step && held_valid_q) begin
				slack_q <= slack_dec;
				if (slack_le) begin
					held_valid_q <= 1'b0;
				end
			end
			if (cmd.fa_dec) begin
				fa_q        <= fa_q - FA_W'(1);
				prev_q      <= b_q;
				have_prev_q <= 1'b1;
			end
			if (cmd.resolve && !fits) begin
				held_val_q   <= res_val;
				slack_q      <= slack_new;
				held_valid_q <= 1'b1;
			end
			if (cmd.resolve || cmd.last_step) begin
				phase_q <= adv_phase[PHASE_W-1:0];
				fa_q    <= fa_q + FA_W'(adv_k);
			end
			if (emit_req && !err_q) begin
				if (too_long) begin
					err_q <= 1'b1;
				end else begin
					count_q <= count_q + COUNT_W'(1);
				end
			end
			if (put_go) begin
				produced_q <= produced_q + PROD_W'(1);
			end
			// end of clip: all clip state back to reset
			if (cmd.last_done) begin
				prev_q       <= '0;
				have_prev_q  <= 1'b0;
				phase_q      <= '0;
				fa_q         <= '0;
				count_q      <= '0;
				err_q        <= 1'b0;
				held_val_q   <= '0;
				held_valid_q <= 1'b0;
				slack_q      <= '0;
			end
		end
	end

	// pending result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q  <= 1'b0;
			pend_sample_q <= '0;
			pend_status_q <= ST_SAMPLE;
			out_valid_q   <= 1'b0;
			out_sample_q  <= '0;
			out_status_q  <= ST_SAMPLE;
			out_last_q    <= 1'b0;
		end else begin
			if (put_go) begin
				pend_valid_q  <= 1'b1;
				pend_sample_q <= put_sample;
				pend_status_q <= put_status;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push_pend) begin
				out_valid_q  <= 1'b1;
				out_sample_q <= pend_sample_q;
				out_status_q <= pend_status_q;
				out_last_q   <= cmd.flush;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ch.ready       = cmd.in_ready;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_sample = out_sample_q;
	assign out_ch.status     = out_status_q;
	assign out_ch.last_out   = out_last_q;

	// status to controller
	assign st.in_valid  = in_ch.valid;
	assign st.in_last   = in_ch.last_frame;
	assign st.have_prev = have_prev_q;
	assign st.last_q    = last_q;
	assign st.fa_zero   = (fa_q == '0);
	assign st.last_cond = (fa_q == '0) && (s <= R1);
	assign st.res_valid = res_valid;
	assign st.put_ok    = !pend_valid_q || out_free;

endmodule

### rtl/lirs_ctrl.sv
// Controller state machine sequencing one input item through the datapath.
`timescale 1ns / 1ps
module lirs_ctrl
	import lirs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t st,
	output cmd_t  cmd
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_HELD  = 6'b000010,
		S_LOOP  = 6'b000100,
		S_WAIT  = 6'b001000,
		S_LAST  = 6'b010000,
		S_FLUSH = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (st.in_valid) begin
					if (st.have_prev) begin
						state_d = S_HELD;
					end else if (st.in_last) begin
						state_d = S_LAST;
					end else begin
						state_d = S_FLUSH;
					end
				end
			end
			S_HELD: begin
				if (st.put_ok) begin
					cmd.held_step = 1'b1;
					state_d = S_LOOP;
				end
			end
			S_LOOP: begin
				if (st.fa_zero) begin
					cmd.start = 1'b1;
					state_d = S_WAIT;
				end else begin
					cmd.fa_dec = 1'b1;
					state_d = st.last_q ? S_LAST : S_FLUSH;
				end
			end
			S_WAIT: begin
				if (st.res_valid && st.put_ok) begin
					cmd.resolve = 1'b1;
					state_d = S_LOOP;
				end
			end
			S_LAST: begin
				if (st.put_ok) begin
					if (st.last_cond) begin
						cmd.last_step = 1'b1;
					end else begin
						cmd.last_done = 1'b1;
						state_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (st.put_ok) begin
					cmd.flush = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/linear_interp_resampler_downmix.sv
// Each interpolated output of an item runs through the four-stage multiply and divide-by-rate
// unit. The first frame of a clip interpolates nothing.
// A final frame adds a closing step after one step per tail sample, and a stalled result
// register holds the item until it frees.
// The block takes one item at a time; a new item is accepted only in the idle state.
// Reset (arst_n low) clears all clip state and sets input_rate 48000, mono.
`timescale 1ns / 1ps
module linear_interp_resampler_downmix
	import lirs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RATE_W-1:0]    cfg_data,
	lirs_in_if.sink              in_ch,
	lirs_out_if.source           out_ch
);
	cmd_t  cmd;
	stat_t st;

	lirs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	lirs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

### sim/linear_interp_resampler_downmix_tb.sv
// Self-checking testbench for the linear-interpolation resampler with stereo downmix.
`timescale 1ns / 1ps
module linear_interp_resampler_downmix_tb
	import lirs_pkg::*;
();

	localparam int CLK_HIGH     = 6;
	localparam int CLK_LOW      = 6;
	localparam int RESET_CYCLES = 9;
	localparam int QUIET_CYCLES = 150;      // covers 12 outputs plus the tail of a clip
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int LONG_HOLD    = 2500;
	localparam int RANDOM_ITEMS = 300;
	localparam int REPORT_LINES = 40;

	// one result as the block should emit it
	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		status_t                    status;
		logic                       last;
	} result_t;

	// tracks the resampler state and checks every emitted result in order
	class resample_scoreboard;
		logic [RATE_W-1:0] rate_reg;
		logic              stereo_reg;
		int                prev_val;
		bit                have_prev;
		int unsigned       frac;
		int unsigned       ahead;
		int unsigned       out_count;
		bit                too_long;
		int                held_val;
		bit                held_valid;
		int                held_slack;
		result_t           step_out[$];
		result_t           due_outputs[$];
		int                errors;
		int                frames;
		int                results;
		int                clips;
		int                empties;

		function new();
			rate_reg   = RATE_W'(48000);
			stereo_reg = 1'b0;
			errors     = 0;
			frames     = 0;
			results    = 0;
			clips      = 0;
			empties    = 0;
			clear_clip();
		endfunction

		function void clear_clip();
			prev_val   = 0;
			have_prev  = 0;
			frac       = 0;
			ahead      = 0;
			out_count  = 0;
			too_long   = 0;
			held_val   = 0;
			held_valid = 0;
			held_slack = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
			if (idx == REG_INPUT_RATE)
				rate_reg = val;
			else if (idx == REG_STEREO)
				stereo_reg = val[0];
		endfunction

		// results past the per-item cap are dropped
		function void put(input int s, input status_t st);
			result_t r;
			if (step_out.size() >= RESULT_CAP)
				return;
			r.sample = s[SAMPLE_W-1:0];
			r.status = st;
			r.last   = 1'b0;
			step_out.push_back(r);
		endfunction

		function void emit(input int v);
			if (too_long)
				return;
			if (out_count >= MAX_OUT) begin
				put(0, ST_TOO_LONG);
				too_long = 1;
				return;
			end
			put(v, ST_SAMPLE);
			out_count++;
		endfunction

		function void advance(input int unsigned rate);
			int unsigned s;
			s = frac + rate;
			ahead += s / OUTPUT_RATE;
			frac = s % OUTPUT_RATE;
		endfunction

		// (a*(OUT-f) + b*f) / OUT, truncated toward zero
		function int lerp(input int a, input int b, input int unsigned f);
			longint t;
			t = longint'(a) * longint'(OUTPUT_RATE - f) + longint'(b) * longint'(f);
			return int'(t / longint'(OUTPUT_RATE));
		endfunction

		// predicts the results caused by one accepted frame
		function void note_frame(input logic signed [SAMPLE_W-1:0] l,
				input logic signed [SAMPLE_W-1:0] r, input logic last);
			int unsigned rate;
			int unsigned need;
			int          a;
			int          b;
			int          v;
			rate = 32'(rate_reg);
			if (rate < RATE_MIN)
				rate = RATE_MIN;
			if (rate > RATE_MAX)
				rate = RATE_MAX;
			b = stereo_reg ? (int'(l) + int'(r)) / 2 : int'(l);
			step_out.delete();
			frames++;
			if (have_prev) begin
				a = prev_val;
				// a held output is released once it is known to lie inside the count
				if (held_valid) begin
					held_slack -= int'(OUTPUT_RATE);
					if (held_slack <= 0) begin
						emit(held_val);
						held_valid = 0;
					end
				end
				while (ahead == 0) begin
					v = lerp(a, b, frac);
					need = frac + rate;
					if (need <= 2 * OUTPUT_RATE) begin
						emit(v);
					end else begin
						held_val   = v;
						held_slack = int'(need - 2 * OUTPUT_RATE);
						held_valid = 1;
					end
					advance(rate);
				end
				ahead--;
			end
			prev_val  = b;
			have_prev = 1;
			// end of clip: next sample clamps to the last one
			if (last) begin
				held_valid = 0;
				while (ahead == 0 && frac + rate <= OUTPUT_RATE) begin
					emit(b);
					advance(rate);
				end
				if (out_count == 0 && !too_long)
					put(0, ST_EMPTY);
				clear_clip();
				clips++;
			end
			if (step_out.size() > 0)
				step_out[$].last = 1'b1;
			foreach (step_out[i])
				due_outputs.push_back(step_out[i]);
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= REPORT_LINES)
				$display("mismatch @%0t: %s", $realtime, msg);
		endtask

		task check_output(input logic signed [SAMPLE_W-1:0] s, input logic [STATUS_W-1:0] st,
				input logic last);
			result_t e;
			results++;
			if (st == ST_EMPTY)
				empties++;
			if (due_outputs.size() == 0) begin
				report($sformatf("unexpected result sample %0d status %0d", s, st));
				return;
			end
			e = due_outputs.pop_front();
			if (st !== e.status)
				report($sformatf("result %0d status %0d, want %0d", results, st, e.status));
			if (s !== e.sample)
				report($sformatf("result %0d sample %0d, want %0d", results, s, e.sample));
			if (last !== e.last)
				report($sformatf("result %0d last_out %0b, want %0b", results, last, e.last));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RATE_W-1:0]    cfg_data;

	lirs_in_if  in_ch();
	lirs_out_if out_ch();

	linear_interp_resampler_downmix DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	resample_scoreboard sb = new();

	bit          hold_request = 1'b0;
	int          long_holds   = 0;
	int          burst_left   = 0;
	int          reg_writes   = 0;
	int unsigned cycle_count  = 0;

	always begin
		#(CLK_LOW) clk = 1'b1;
		#(CLK_HIGH) clk = 1'b0;
	end

	// cycle counter and run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run limit of %0d cycles reached", CYCLE_LIMIT);
		$display("[linear_interp_resampler_downmix] ERROR");
		$finish;
	end

	// result side: checks accepted items, stalls on its own pattern
	initial begin
		int unsigned pattern;
		int          span;
		int          hold_left;
		int          bit_pos;
		out_ch.ready <= 1'b0;
		pattern   = '1;
		span      = 0;
		hold_left = 0;
		bit_pos   = 0;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				sb.check_output(out_ch.out_sample, out_ch.status, out_ch.last_out);
			if (hold_request && hold_left == 0) begin
				hold_left    = LONG_HOLD;
				hold_request = 1'b0;
				long_holds++;
			end
			// new stall pattern at the end of each random span
			if (span == 0) begin
				span = $urandom_range(256, 32);
				case ($urandom_range(3, 0))
					0: pattern = '1;
					1: pattern = $urandom();
					2: pattern = $urandom() | $urandom();
					default: pattern = $urandom() & $urandom();
				endcase
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= pattern[bit_pos];
			end
			bit_pos = (bit_pos + 1) % 32;
		end
	end

	task automatic idle_for(input int n);
		in_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// offers one item, in bursts with random gaps between them
	task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r, input logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			if ($urandom_range(3, 0) != 0)
				idle_for($urandom_range(9, 1));
		end
		burst_left--;
		in_ch.valid        <= 1'b1;
		in_ch.left_sample  <= l;
		in_ch.right_sample <= r;
		in_ch.last_frame   <= last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_frame(l, r, last);
	endtask

	// waits for every owed result, then lets the block settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.due_outputs.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, val);
		reg_writes++;
	endtask

	// one clip of random content; close=0 leaves it open for the next setting
	task automatic send_clip(input int len, input bit close);
		int                         style;
		int                         walk;
		int                         wr;
		logic signed [SAMPLE_W-1:0] l;
		logic signed [SAMPLE_W-1:0] r;
		style = $urandom_range(3, 0);
		walk  = int'($urandom_range(60000)) - 30000;
		for (int i = 0; i < len; i++) begin
			case (style)
				0: begin
					l = SAMPLE_W'($urandom());
					r = SAMPLE_W'($urandom());
				end
				1: begin
					l = $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
					r = $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
				end
				default: begin
					// slow wander, right close to left
					walk += int'($urandom_range(2000)) - 1000;
					if (walk > 30000)
						walk = 30000;
					if (walk < -30000)
						walk = -30000;
					wr = walk + int'($urandom_range(512)) - 256;
					l  = walk[SAMPLE_W-1:0];
					r  = wr[SAMPLE_W-1:0];
				end
			endcase
			send_frame(l, r, close && (i == len - 1));
		end
	endtask

	// new rate and channel mode for a phase
	task automatic pick_settings();
		int unsigned rate_edges[6]  = '{0, 7999, 8000, 192000, 192001, 262143};
		int unsigned rate_common[5] = '{11025, 22050, 44100, 48000, 96000};
		int unsigned rate;
		case ($urandom_range(9, 0))
			0, 1: rate = rate_edges[$urandom_range(5, 0)];
			2, 3: rate = rate_common[$urandom_range(4, 0)];
			default: rate = $urandom_range(192000, 8000);
		endcase
		write_reg(REG_INPUT_RATE, rate[RATE_W-1:0]);
		write_reg(REG_STEREO, RATE_W'($urandom()));
	endtask

	// main sequence
	initial begin
		int target;
		int quota;
		int phase_no;
		int len;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= '0;
		cfg_data           <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.left_sample  <= '0;
		in_ch.right_sample <= '0;
		in_ch.last_frame   <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 48 kHz mono, rail to rail, then a one-frame clip
		send_frame(16'sh7fff, 16'sh0000, 1'b0);
		send_frame(16'sh8000, 16'sh7fff, 1'b0);
		send_frame(16'sh0000, 16'sh8000, 1'b1);
		send_frame(16'sh8000, 16'sh0000, 1'b1);
		drain();

		// top rate: a one-frame clip yields only the empty-clip flag
		write_reg(REG_INPUT_RATE, RATE_W'(192000));
		send_frame(16'sh1234, 16'sh0000, 1'b1);
		drain();

		// above the top rate saturates; the held output is dropped at the end
		write_reg(REG_INPUT_RATE, '1);
		send_frame(16'sh7fff, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh7fff, 1'b1);
		drain();

		// rate 0 saturates to the bottom; stereo downmix truncates toward zero
		write_reg(REG_INPUT_RATE, '0);
		write_reg(REG_STEREO, '1);
		send_frame(16'sh7fff, 16'sh7fff, 1'b0);
		send_frame(16'sh8000, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh7fff, 1'b0);
		send_frame(-16'sd3, 16'sh0000, 1'b0);
		send_frame(16'sh7fff, 16'sh8000, 1'b1);
		drain();

		// mono ignores the right channel
		write_reg(REG_STEREO, '0);
		write_reg(REG_INPUT_RATE, RATE_W'(7999));
		send_frame(16'sh4000, 16'sh7fff, 1'b0);
		send_frame(-16'sd1, 16'sh8000, 1'b0);
		send_frame(16'sh0001, 16'sh5555, 1'b1);
		drain();

		// just over twice the output rate: outputs are held a step
		write_reg(REG_INPUT_RATE, RATE_W'(97000));
		send_frame(16'sh0100, 16'sh0000, 1'b0);
		send_frame(16'sh7fff, 16'sh0000, 1'b0);
		send_frame(16'sh8000, 16'sh0000, 1'b0);
		send_frame(16'sh2000, 16'sh0000, 1'b0);
		send_frame(-16'sd2000, 16'sh0000, 1'b0);
		send_frame(16'sh0fff, 16'sh0000, 1'b1);
		drain();

		// rate change inside a clip with an output held
		write_reg(REG_INPUT_RATE, RATE_W'(100000));
		send_frame(16'sh1000, 16'sh0000, 1'b0);
		send_frame(-16'sd4096, 16'sh0000, 1'b0);
		drain();
		write_reg(REG_INPUT_RATE, RATE_W'(8000));
		send_frame(16'sh7000, 16'sh0000, 1'b1);
		drain();

		// random phases, each with its own setting
		target   = sb.frames + RANDOM_ITEMS;
		phase_no = 0;
		while (sb.frames < target) begin
			pick_settings();
			if (phase_no == 2)
				hold_request = 1'b1;
			quota = sb.frames + $urandom_range(60, 25);
			while (sb.frames < quota) begin
				len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
				send_clip(len, 1'b1);
			end
			// sometimes leave a clip open across the setting change
			if ($urandom_range(2, 0) == 0)
				send_clip($urandom_range(6, 1), 1'b0);
			drain();
			phase_no++;
		end

		$display("ran %0d frames in %0d clips over %0d phases, %0d register writes",
			sb.frames, sb.clips, phase_no, reg_writes);
		$display("checked %0d results (%0d empty-clip flags), %0d long receiver hold(s)",
			sb.results, sb.empties, long_holds);
		if (sb.errors == 0 && sb.due_outputs.size() == 0)
			$display("[linear_interp_resampler_downmix] OK");
		else
			$display("[linear_interp_resampler_downmix] ERROR");
		$finish;
	end

endmodule
